[rtl/plt_pkg.sv]
`timescale 1ns / 1ps
package plt_pkg;

	// default widths
	localparam int COORD_WIDTH_DEF = 24;
	localparam int SUM_WIDTH_DEF   = 48;
	localparam int FIT_WIDTH       = 48;
	localparam int WEIGHT_WIDTH    = 16;
	localparam int FACTOR_WIDTH    = 4;
	localparam int ADDR_WIDTH      = 4;
	localparam int QUEUE_DEPTH     = 2;

	// angle unit
	localparam int ANG_STEPS = 18;
	localparam int ZW        = 26;
	localparam int ANG_WIDTH = 16;
	localparam int NORM_HI   = 32768;
	localparam int NORM_LO   = 16384;
	localparam logic signed [ZW-1:0] Z_90  = ZW'(90 * 65536);
	localparam logic signed [ZW-1:0] Z_180 = ZW'(180 * 65536);
	localparam logic [ANG_WIDTH-1:0] ANG_REVERSE = ANG_WIDTH'(180 * 256);

	// register map
	localparam logic [1:0] REG_DIST  = 2'd0;
	localparam logic [1:0] REG_ANGLE = 2'd1;
	localparam logic [1:0] REG_CURVE = 2'd2;
	localparam logic [WEIGHT_WIDTH-1:0] DIST_WEIGHT_RST  = 16'd26214;
	localparam logic [WEIGHT_WIDTH-1:0] ANGLE_WEIGHT_RST = 16'd39322;
	localparam logic [FACTOR_WIDTH-1:0] CURVE_FACTOR_RST = 4'd3;

	typedef struct packed {
		logic [WEIGHT_WIDTH-1:0] dist_weight;
		logic [WEIGHT_WIDTH-1:0] angle_weight;
		logic [FACTOR_WIDTH-1:0] curve_factor;
	} cfg_t;

	// what the back end has to do for one point
	typedef struct packed {
		logic do_angle;
		logic do_len;
		logic curve;
		logic last;
		logic few;
	} job_ctrl_t;

	typedef enum logic [3:0] {
		B_IDLE, B_DISPATCH, B_NORM, B_MUL_A, B_MUL_B, B_PREP, B_CORDIC, B_CLAMP,
		B_ANG_ADD, B_SQ_MUL, B_SQ_ADD, B_SQ_RUN, B_LEN_ADD, B_FIT, B_FIT_END, B_OUT
	} back_state_t;

	// arctangent of 2^-i in Q.16 degrees
	function automatic logic [ZW-1:0] atan_q16(input logic [4:0] i);
		logic [ZW-1:0] r;
		case (i)
			5'd0:  r = ZW'(2949120);
			5'd1:  r = ZW'(1740967);
			5'd2:  r = ZW'(919879);
			5'd3:  r = ZW'(466945);
			5'd4:  r = ZW'(234379);
			5'd5:  r = ZW'(117304);
			5'd6:  r = ZW'(58666);
			5'd7:  r = ZW'(29335);
			5'd8:  r = ZW'(14668);
			5'd9:  r = ZW'(7334);
			5'd10: r = ZW'(3667);
			5'd11: r = ZW'(1833);
			5'd12: r = ZW'(917);
			5'd13: r = ZW'(458);
			5'd14: r = ZW'(229);
			5'd15: r = ZW'(115);
			5'd16: r = ZW'(57);
			5'd17: r = ZW'(29);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[rtl/path_length_turning_cost_unit.sv]
`timescale 1ns / 1ps
// Path cost unit: polyline points stream in on the s_ side, one word per point, and one cost
// word leaves on the m_ side for each point marked tlast. A front end keeps the last two points,
// forms the segment vectors and pushes one job per point into a two-word queue, so it can take
// new points while the back end works. The back end is one sequencer that runs the jobs through
// shared units: a shift normalizer, products in B_MUL_A and B_MUL_B, an 18-step CORDIC for
// the turning angle, and a digit-by-digit square root of COORD_WIDTH+2 steps for the segment
// length. The CORDIC is skipped where the path runs straight on or reverses. The first point
// of a path is only recorded; the second adds a segment length but no turning angle. The last
// point of a path of three points or more adds the weighted sum, and every last point hands
// off its result. The user must write the registers over the APB port only while idle; the
// block itself does not enforce it.
module path_length_turning_cost_unit #(
	parameter int COORD_WIDTH = plt_pkg::COORD_WIDTH_DEF,
	parameter int SUM_WIDTH   = plt_pkg::SUM_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// slave stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,  // x, y
	input  logic                                 s_tuser,  // curve flag
	input  logic                                 s_tlast,  // last
	// master stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [plt_pkg::FIT_WIDTH-1:0]        m_tdata,  // fitness
	output logic                                 m_tuser,  // too_few_points
	// config port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [plt_pkg::ADDR_WIDTH-1:0]       paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);
	import plt_pkg::*;

	localparam int D  = COORD_WIDTH + 1;
	localparam int QW = $bits(job_ctrl_t) + 4 * D;

	cfg_t cfg_q;

	// register file
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dist_weight  <= DIST_WEIGHT_RST;
			cfg_q.angle_weight <= ANGLE_WEIGHT_RST;
			cfg_q.curve_factor <= CURVE_FACTOR_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_DIST:  cfg_q.dist_weight  <= pwdata[WEIGHT_WIDTH-1:0];
				REG_ANGLE: cfg_q.angle_weight <= pwdata[WEIGHT_WIDTH-1:0];
				REG_CURVE: cfg_q.curve_factor <= pwdata[FACTOR_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_DIST:  prdata = 32'(cfg_q.dist_weight);
			REG_ANGLE: prdata = 32'(cfg_q.angle_weight);
			REG_CURVE: prdata = 32'(cfg_q.curve_factor);
			default:   prdata = '0;
		endcase
	end

	// front end
	logic             q_full, push, q_ne, pop;
	job_ctrl_t        f_ctrl, b_ctrl;
	logic [D-1:0]     f_ax, f_ay, f_bx, f_by, b_ax, b_ay, b_bx, b_by;
	logic [QW-1:0]    q_rdata;

	plt_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.x        (s_tdata[COORD_WIDTH-1:0]),
		.y        (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
		.curve_pt (s_tuser),
		.last     (s_tlast),
		.q_full   (q_full),
		.push     (push),
		.ctrl     (f_ctrl),
		.ax       (f_ax),
		.ay       (f_ay),
		.bx       (f_bx),
		.by       (f_by)
	);

	// job queue
	plt_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     ({f_ctrl, f_ax, f_ay, f_bx, f_by}),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_ne),
		.rdata     (q_rdata)
	);

	assign {b_ctrl, b_ax, b_ay, b_bx, b_by} = q_rdata;

	// back end
	plt_back #(.COORD_WIDTH(COORD_WIDTH), .SUM_WIDTH(SUM_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_ne),
		.job_pop   (pop),
		.job_ctrl  (b_ctrl),
		.jax       (b_ax),
		.jay       (b_ay),
		.jbx       (b_bx),
		.jby       (b_by),
		.cfg       (cfg_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.fitness   (m_tdata),
		.few       (m_tuser)
	);

endmodule

[rtl/plt_front.sv]
`timescale 1ns / 1ps
module plt_front #(
	parameter int COORD_WIDTH = plt_pkg::COORD_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [COORD_WIDTH-1:0]  x,
	input  logic [COORD_WIDTH-1:0]  y,
	input  logic                    curve_pt,
	input  logic                    last,
	input  logic                    q_full,
	output logic                    push,
	output plt_pkg::job_ctrl_t      ctrl,
	output logic [COORD_WIDTH:0]    ax,
	output logic [COORD_WIDTH:0]    ay,
	output logic [COORD_WIDTH:0]    bx,
	output logic [COORD_WIDTH:0]    by
);
	import plt_pkg::*;

	localparam int CW = COORD_WIDTH;

	logic [CW-1:0] older_x_q, older_y_q, newer_x_q, newer_y_q;
	logic          newer_curve_q;
	logic [1:0]    seen_q;

	// accept whenever the queue has room
	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	// segment vectors
	assign ax = {newer_x_q[CW-1], newer_x_q} - {older_x_q[CW-1], older_x_q};
	assign ay = {newer_y_q[CW-1], newer_y_q} - {older_y_q[CW-1], older_y_q};
	assign bx = {x[CW-1], x} - {newer_x_q[CW-1], newer_x_q};
	assign by = {y[CW-1], y} - {newer_y_q[CW-1], newer_y_q};

	// classify the point
	always_comb begin
		ctrl.do_angle = (seen_q >= 2'd2);
		ctrl.do_len   = (seen_q >= 2'd1);
		ctrl.curve    = newer_curve_q;
		ctrl.last     = last;
		ctrl.few      = (seen_q < 2'd2);
	end

	// point history, cleared at path end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_x_q     <= '0;
			older_y_q     <= '0;
			newer_x_q     <= '0;
			newer_y_q     <= '0;
			newer_curve_q <= 1'b0;
			seen_q        <= 2'd0;
		end else if (push) begin
			if (last) begin
				older_x_q     <= '0;
				older_y_q     <= '0;
				newer_x_q     <= '0;
				newer_y_q     <= '0;
				newer_curve_q <= 1'b0;
				seen_q        <= 2'd0;
			end else begin
				older_x_q     <= newer_x_q;
				older_y_q     <= newer_y_q;
				newer_x_q     <= x;
				newer_y_q     <= y;
				newer_curve_q <= curve_pt;
				if (seen_q != 2'd3) begin
					seen_q <= seen_q + 2'd1;
				end
			end
		end
	end

endmodule

[rtl/plt_queue.sv]
`timescale 1ns / 1ps
module plt_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] rdata
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [NW-1:0]    cnt_q;

	assign full      = (cnt_q == NW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rdata     = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/plt_back.sv]
`timescale 1ns / 1ps
module plt_back #(
	parameter int COORD_WIDTH = plt_pkg::COORD_WIDTH_DEF,
	parameter int SUM_WIDTH   = plt_pkg::SUM_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           job_valid,
	output logic                           job_pop,
	input  plt_pkg::job_ctrl_t             job_ctrl,
	input  logic [COORD_WIDTH:0]           jax,
	input  logic [COORD_WIDTH:0]           jay,
	input  logic [COORD_WIDTH:0]           jbx,
	input  logic [COORD_WIDTH:0]           jby,
	input  plt_pkg::cfg_t                  cfg,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [plt_pkg::FIT_WIDTH-1:0]  fitness,
	output logic                           few
);
	import plt_pkg::*;

	localparam int D     = COORD_WIDTH + 1;
	localparam int S     = SUM_WIDTH;
	localparam int NMW   = (D > 16) ? D : 16;
	localparam int RADW  = 2 * (D + 1);
	localparam int REMW  = D + 4;
	localparam int SQS   = D + 1;
	localparam int SCW   = $clog2(SQS);
	localparam int XW    = 44;
	localparam int AW    = ((S > D + 1) ? S : D + 1) + 1;
	localparam int NCH   = (S + 31) / 32;
	localparam int CKW   = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int PADW  = NCH * 32;
	localparam int ACCW  = S + 18;
	localparam int FULLW = (S + 2 > FIT_WIDTH + 1) ? S + 2 : FIT_WIDTH + 1;

	back_state_t state_q, state_d;
	job_ctrl_t   ctrl_q;
	logic        out_load;

	logic signed [D-1:0]    ax_q, ay_q, bx_q, by_q;
	logic [NMW-1:0]         na_x_q, na_y_q, nb_x_q, nb_y_q;
	logic signed [31:0]     p0_q, p1_q, p2_q, p3_q;
	logic signed [32:0]     d_q;
	logic signed [XW-1:0]   cx_q, cy_q;
	logic signed [ZW-1:0]   z_q;
	logic [4:0]             cnt_q;
	logic [ANG_WIDTH-1:0]   ang_q;
	logic [2*D-1:0]         sqx_q, sqy_q;
	logic [RADW-1:0]        rad_q;
	logic [REMW-1:0]        rem_q;
	logic [D:0]             root_q;
	logic [SCW-1:0]         scnt_q;
	logic [S-1:0]           len_sum_q, ang_sum_q;
	logic [ACCW-1:0]        acc_q;
	logic [47:0]            prod_q;
	logic [CKW-1:0]         pck_q, fck_q;
	logic                   prod_v_q, fsel_q;
	logic                   out_valid_q, few_q;
	logic [FIT_WIDTH-1:0]   fit_q;

	// magnitudes of the latched vectors
	logic [D-1:0] m_ax, m_ay, m_bx, m_by;
	assign m_ax = ax_q[D-1] ? D'(-ax_q) : D'(ax_q);
	assign m_ay = ay_q[D-1] ? D'(-ay_q) : D'(ay_q);
	assign m_bx = bx_q[D-1] ? D'(-bx_q) : D'(bx_q);
	assign m_by = by_q[D-1] ? D'(-by_q) : D'(by_q);

	logic a_zero, b_zero;
	assign a_zero = (ax_q == '0) && (ay_q == '0);
	assign b_zero = (bx_q == '0) && (by_q == '0);

	// normalization range checks
	logic [NMW-1:0] ma, mb;
	logic           a_hi, a_lo, b_hi, b_lo, norm_done;
	assign ma = (na_x_q > na_y_q) ? na_x_q : na_y_q;
	assign mb = (nb_x_q > nb_y_q) ? nb_x_q : nb_y_q;
	assign a_hi = (ma >= NMW'(NORM_HI));
	assign a_lo = (ma <  NMW'(NORM_LO));
	assign b_hi = (mb >= NMW'(NORM_HI));
	assign b_lo = (mb <  NMW'(NORM_LO));
	assign norm_done = !a_hi && !a_lo && !b_hi && !b_lo;

	// signed normalized components
	logic signed [15:0] sax, say, sbx, sby;
	assign sax = ax_q[D-1] ? -$signed({1'b0, na_x_q[14:0]}) : $signed({1'b0, na_x_q[14:0]});
	assign say = ay_q[D-1] ? -$signed({1'b0, na_y_q[14:0]}) : $signed({1'b0, na_y_q[14:0]});
	assign sbx = bx_q[D-1] ? -$signed({1'b0, nb_x_q[14:0]}) : $signed({1'b0, nb_x_q[14:0]});
	assign sby = by_q[D-1] ? -$signed({1'b0, nb_y_q[14:0]}) : $signed({1'b0, nb_y_q[14:0]});

	// cross product and scaled operands
	logic signed [32:0]   c_w, c_abs;
	logic signed [XW-1:0] d256, c256;
	assign c_w   = 33'(p2_q) - 33'(p3_q);
	assign c_abs = c_w[32] ? -c_w : c_w;
	assign d256  = XW'(d_q) <<< 8;
	assign c256  = XW'(c_abs) <<< 8;

	// one vectoring step
	logic signed [XW-1:0] sx, sy;
	logic signed [ZW-1:0] at;
	logic                 y_pos;
	assign sx    = cy_q >>> cnt_q;
	assign sy    = cx_q >>> cnt_q;
	assign at    = $signed(atan_q16(cnt_q));
	assign y_pos = !cy_q[XW-1] && (cy_q != '0);

	// clamp and round the angle
	logic signed [ZW-1:0] zc;
	assign zc = z_q[ZW-1] ? '0 : ((z_q > Z_180) ? Z_180 : z_q);

	// weighted angle and saturating sums
	logic [FACTOR_WIDTH-1:0] mult;
	logic [19:0]             av;
	logic [S:0]              asum_w;
	logic [AW-1:0]           lsum_w;
	assign mult   = ctrl_q.curve ? cfg.curve_factor : FACTOR_WIDTH'(1);
	assign av     = ang_q * mult;
	assign asum_w = (S+1)'(ang_sum_q) + (S+1)'(av);
	assign lsum_w = AW'(len_sum_q) + AW'(root_q);

	// square root digit step
	logic [REMW-1:0] remsh, trial;
	logic            ge;
	assign remsh = {rem_q[REMW-3:0], rad_q[RADW-1:RADW-2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = (remsh >= trial);

	// weight by sum chunk
	logic [S-1:0]        fsrc;
	logic [WEIGHT_WIDTH-1:0] fw;
	logic [PADW-1:0]     fpad;
	logic [31:0]         chunk;
	logic                fit_last;
	assign fsrc     = fsel_q ? ang_sum_q : len_sum_q;
	assign fw       = fsel_q ? cfg.angle_weight : cfg.dist_weight;
	assign fpad     = PADW'(fsrc);
	assign chunk    = fpad[fck_q*32 +: 32];
	assign fit_last = fsel_q && (fck_q == CKW'(NCH - 1));

	// rounding and saturation of the final cost
	logic [ACCW-1:0]      rnd;
	logic [FULLW-1:0]     full;
	logic [FIT_WIDTH-1:0] fit_val;
	assign rnd     = acc_q + ACCW'(32768);
	assign full    = FULLW'(rnd[ACCW-1:16]);
	assign fit_val = (|full[FULLW-1:FIT_WIDTH]) ? '1 : full[FIT_WIDTH-1:0];

	// sequencer outputs
	always_comb begin
		job_pop  = (state_q == B_IDLE) && job_valid;
		out_load = (state_q == B_OUT) && (!out_valid_q || out_ready);
	end

	// next state
	always_comb begin
		back_state_t end_st;
		end_st  = ctrl_q.last ? (ctrl_q.few ? B_OUT : B_FIT) : B_IDLE;
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (job_valid) state_d = B_DISPATCH;
			end
			B_DISPATCH: begin
				if (ctrl_q.do_angle && !a_zero && !b_zero) state_d = B_NORM;
				else if (ctrl_q.do_len) state_d = B_SQ_MUL;
				else state_d = end_st;
			end
			B_NORM: begin
				if (norm_done) state_d = B_MUL_A;
			end
			B_MUL_A: state_d = B_MUL_B;
			B_MUL_B: state_d = B_PREP;
			B_PREP: begin
				state_d = (c_w == '0) ? B_ANG_ADD : B_CORDIC;
			end
			B_CORDIC: begin
				if (cnt_q == 5'(ANG_STEPS - 1)) state_d = B_CLAMP;
			end
			B_CLAMP:   state_d = B_ANG_ADD;
			B_ANG_ADD: state_d = B_SQ_MUL;
			B_SQ_MUL:  state_d = B_SQ_ADD;
			B_SQ_ADD:  state_d = B_SQ_RUN;
			B_SQ_RUN: begin
				if (scnt_q == SCW'(SQS - 1)) state_d = B_LEN_ADD;
			end
			B_LEN_ADD: state_d = end_st;
			B_FIT: begin
				if (fit_last) state_d = B_FIT_END;
			end
			B_FIT_END: state_d = B_OUT;
			B_OUT: begin
				if (out_load) state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			prod_v_q    <= 1'b0;
			len_sum_q   <= '0;
			ang_sum_q   <= '0;
		end else begin
			state_q  <= state_d;
			prod_v_q <= (state_q == B_FIT);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == B_ANG_ADD) begin
				ang_sum_q <= asum_w[S] ? '1 : asum_w[S-1:0];
			end
			if (state_q == B_LEN_ADD) begin
				len_sum_q <= (lsum_w > AW'({S{1'b1}})) ? '1 : lsum_w[S-1:0];
			end
			if (out_load) begin
				len_sum_q <= '0;
				ang_sum_q <= '0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (job_pop) begin
			ctrl_q <= job_ctrl;
			ax_q   <= jax;
			ay_q   <= jay;
			bx_q   <= jbx;
			by_q   <= jby;
		end
		case (state_q)
			B_DISPATCH: begin
				na_x_q <= NMW'(m_ax);
				na_y_q <= NMW'(m_ay);
				nb_x_q <= NMW'(m_bx);
				nb_y_q <= NMW'(m_by);
				acc_q  <= '0;
				fsel_q <= 1'b0;
				fck_q  <= '0;
				ang_q  <= '0;
			end
			B_NORM: begin
				if (a_hi) begin
					na_x_q <= na_x_q >> 1;
					na_y_q <= na_y_q >> 1;
				end else if (a_lo) begin
					na_x_q <= na_x_q << 1;
					na_y_q <= na_y_q << 1;
				end
				if (b_hi) begin
					nb_x_q <= nb_x_q >> 1;
					nb_y_q <= nb_y_q >> 1;
				end else if (b_lo) begin
					nb_x_q <= nb_x_q << 1;
					nb_y_q <= nb_y_q << 1;
				end
			end
			B_MUL_A: begin
				p0_q <= sax * sbx;
				p1_q <= say * sby;
			end
			B_MUL_B: begin
				d_q  <= 33'(p0_q) + 33'(p1_q);
				p2_q <= sax * sby;
				p3_q <= say * sbx;
			end
			B_PREP: begin
				cnt_q <= '0;
				if (c_w == '0) begin
					ang_q <= (d_q > 0) ? '0 : ANG_REVERSE;
				end else if (d_q[32]) begin
					cx_q <= c256;
					cy_q <= -d256;
					z_q  <= Z_90;
				end else begin
					cx_q <= d256;
					cy_q <= c256;
					z_q  <= '0;
				end
			end
			B_CORDIC: begin
				cnt_q <= cnt_q + 5'd1;
				if (y_pos) begin
					cx_q <= cx_q + sx;
					cy_q <= cy_q - sy;
					z_q  <= z_q + at;
				end else begin
					cx_q <= cx_q - sx;
					cy_q <= cy_q + sy;
					z_q  <= z_q - at;
				end
			end
			B_CLAMP: begin
				ang_q <= ANG_WIDTH'((ZW'(zc) + ZW'(128)) >> 8);
			end
			B_SQ_MUL: begin
				sqx_q <= m_bx * m_bx;
				sqy_q <= m_by * m_by;
			end
			B_SQ_ADD: begin
				rad_q  <= RADW'(sqx_q) + RADW'(sqy_q);
				rem_q  <= '0;
				root_q <= '0;
				scnt_q <= '0;
			end
			B_SQ_RUN: begin
				rem_q  <= ge ? remsh - trial : remsh;
				root_q <= {root_q[D-1:0], ge};
				rad_q  <= rad_q << 2;
				scnt_q <= scnt_q + 1'b1;
			end
			B_FIT: begin
				prod_q <= fw * chunk;
				pck_q  <= fck_q;
				if (fck_q == CKW'(NCH - 1)) begin
					fck_q  <= '0;
					fsel_q <= 1'b1;
				end else begin
					fck_q <= fck_q + 1'b1;
				end
			end
			default: ;
		endcase
		// partial products are added to the accumulator in the cycle after they are formed
		if (prod_v_q) begin
			acc_q <= acc_q + (ACCW'(prod_q) << (32 * pck_q));
		end
		if (out_load) begin
			fit_q <= ctrl_q.few ? '0 : fit_val;
			few_q <= ctrl_q.few;
		end
	end

	assign out_valid = out_valid_q;
	assign fitness   = fit_q;
	assign few       = few_q;

endmodule

[rtl/plt_checker.sv]
`timescale 1ns / 1ps
module plt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tuser
);

	// a stalled word stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	// a stalled word keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result payload changed while stalled");

	// a short path reports zero cost
	a_few_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 48'd0)
		else $error("short path with nonzero cost");

	// nothing is offered in reset
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("result offered during reset");

endmodule

bind path_length_turning_cost_unit plt_checker u_plt_checker (.*);

[tb/tb_path_length_turning_cost_unit.sv]
`timescale 1ns / 1ps
module tb_path_length_turning_cost_unit;
	import plt_pkg::*;

	localparam int CW = COORD_WIDTH_DEF;
	localparam int SW = SUM_WIDTH_DEF;
	localparam longint unsigned SUM_TOP = (64'd1 << SW) - 1;
	localparam longint unsigned FIT_TOP = (64'd1 << FIT_WIDTH) - 1;
	localparam int SETTLE = 200;

	typedef struct {
		logic [FIT_WIDTH-1:0] fitness;
		logic                 few;
	} cost_word_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, s_tuser, s_tlast;
	logic [((2*CW+7)/8)*8-1:0] s_tdata;  // x, y
	logic m_tvalid, m_tready, m_tuser;
	logic [FIT_WIDTH-1:0] m_tdata;        // fitness
	logic psel, penable, pwrite, pready;
	logic [ADDR_WIDTH-1:0] paddr;
	logic [31:0] pwdata, prdata;

	path_length_turning_cost_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predicted cost state
	longint unsigned w_dist, w_angle, k_curve;
	longint prev_x, prev_y, cur_x, cur_y;
	bit cur_curve;
	int pts;
	longint unsigned len_acc, ang_acc;
	cost_word_t cost_q[$];
	int errors = 0;
	int burst_left = 0;
	longint cyc = 0;

	const longint atan_q16_tab[ANG_STEPS] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335, 14668,
		7334, 3667, 1833, 917, 458, 229, 115, 57, 29
	};

	function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
		if (a > SUM_TOP) a = SUM_TOP;
		return (b > SUM_TOP - a) ? SUM_TOP : a + b;
	endfunction

	// floor of the exact euclidean length
	function automatic longint unsigned seg_len(longint dx, longint dy);
		bit [127:0] v;
		bit [127:0] sq;
		longint unsigned r, c;
		v = 128'(dx * dx) + 128'(dy * dy);
		r = 0;
		for (int b = 33; b >= 0; b--) begin
			c = r | (64'd1 << b);
			sq = 128'(c) * 128'(c);
			if (sq <= v) r = c;
		end
		return r;
	endfunction

	// scale so the larger component lies in [2^14, 2^15)
	function automatic void scale_vec(inout longint a, inout longint b);
		longint ma, mb, m;
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		m = ma > mb ? ma : mb;
		while (m >= NORM_HI) begin ma >>= 1; mb >>= 1; m >>= 1; end
		while (m < NORM_LO) begin ma <<= 1; mb <<= 1; m <<= 1; end
		a = a < 0 ? -ma : ma;
		b = b < 0 ? -mb : mb;
	endfunction

	// turning angle in q.8 degrees via cordic vectoring
	function automatic longint unsigned turn_q8(longint ax, longint ay, longint bx, longint by);
		longint d, c, xx, yy, z, sx, sy;
		if ((ax == 0 && ay == 0) || (bx == 0 && by == 0)) return 0;
		scale_vec(ax, ay);
		scale_vec(bx, by);
		d = ax * bx + ay * by;
		c = ax * by - ay * bx;
		if (c < 0) c = -c;
		if (c == 0) return d > 0 ? 0 : 180 * 256;
		d *= 256;
		c *= 256;
		z = 0;
		if (d < 0) begin
			z = 90 * 65536; xx = c; yy = -d;
		end else begin
			xx = d; yy = c;
		end
		for (int i = 0; i < ANG_STEPS; i++) begin
			sx = yy >>> i;
			sy = xx >>> i;
			if (yy > 0) begin
				xx += sx; yy -= sy; z += atan_q16_tab[i];
			end else begin
				xx -= sx; yy += sy; z -= atan_q16_tab[i];
			end
		end
		if (z < 0) z = 0;
		if (z > 180 * 65536) z = 180 * 65536;
		return longint'(z + 128) >> 8;
	endfunction

	function automatic void clear_path();
		prev_x = 0; prev_y = 0; cur_x = 0; cur_y = 0;
		cur_curve = 0; pts = 0; len_acc = 0; ang_acc = 0;
	endfunction

	// advance the predicted path by one point, queue the cost on a path end
	function automatic void predict_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
			bit curve, bit fin);
		longint px, py;
		longint unsigned a;
		bit [79:0] s;
		cost_word_t w;
		px = x;
		py = y;
		if (pts >= 2) begin
			a = turn_q8(cur_x - prev_x, cur_y - prev_y, px - cur_x, py - cur_y);
			ang_acc = sat_sum(ang_acc, a * (cur_curve ? k_curve : 1));
		end
		if (pts >= 1) len_acc = sat_sum(len_acc, seg_len(px - cur_x, py - cur_y));
		prev_x = cur_x; prev_y = cur_y;
		cur_x = px; cur_y = py;
		cur_curve = curve;
		if (pts < 3) pts++;
		if (!fin) return;
		if (pts < 3) begin
			w.fitness = '0; w.few = 1;
		end else begin
			s = 80'(w_dist) * 80'(len_acc) + 80'(w_angle) * 80'(ang_acc) + 80'd32768;
			s = s >> 16;
			w.fitness = (s > 80'(FIT_TOP)) ? FIT_WIDTH'(FIT_TOP) : s[FIT_WIDTH-1:0];
			w.few = 0;
		end
		cost_q.push_back(w);
		clear_path();
	endfunction

	// clock and cycle count
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cyc <= cyc + 1;

	// receiver stalls: steady, random and a fixed on/off pattern in turn
	always @(negedge clk) begin
		case ((cyc / 700) % 3)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			default: m_tready <= ((cyc % 7) < 3);
		endcase
	end

	// cost word checker
	always @(posedge clk) begin
		cost_word_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (cost_q.size() == 0) begin
				$display("%0t: unexpected word fitness=%0d few=%0b", $time, m_tdata, m_tuser);
				errors++;
			end else begin
				e = cost_q.pop_front();
				if (m_tdata !== e.fitness) begin
					$display("%0t: fitness expected %0d actual %0d", $time, e.fitness, m_tdata);
					errors++;
				end
				if (m_tuser !== e.few) begin
					$display("%0t: too_few_points expected %0b actual %0b", $time, e.few,
						m_tuser);
					errors++;
				end
			end
		end
	end

	// send one point, with random bursts and gaps
	task automatic send_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
			bit curve, bit fin);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 12)) @(negedge clk);
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {y, x};
		s_tuser <= curve;
		s_tlast <= fin;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_point(x, y, curve, fin);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (cost_q.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// write a register and read it back
	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		logic [31:0] want;
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 0;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		case (idx)
			REG_DIST: begin w_dist = val[15:0]; want = 32'(val[15:0]); end
			REG_ANGLE: begin w_angle = val[15:0]; want = 32'(val[15:0]); end
			default: begin k_curve = val[3:0]; want = 32'(val[3:0]); end
		endcase
		if (prdata !== want) begin
			$display("%0t: register %0d expected %0d actual %0d", $time, idx, want, prdata);
			errors++;
		end
		@(negedge clk);
		psel <= 0; penable <= 0;
	endtask

	task automatic test_short_paths();
		send_point(24'sd512, -24'sd300, 1, 1);
		send_point(0, 0, 0, 0);
		send_point(24'sd256, 0, 1, 1);
		// straight line and full reversal at a curve point
		send_point(0, 0, 0, 0);
		send_point(24'sd256, 0, 0, 0);
		send_point(24'sd512, 0, 0, 1);
		send_point(0, 0, 0, 0);
		send_point(24'sd256, 0, 1, 0);
		send_point(0, 0, 0, 1);
		// coordinate extremes
		send_point(24'sh800000, 24'sh800000, 0, 0);
		send_point(24'sd8388607, 24'sd8388607, 1, 0);
		send_point(24'sh800000, 24'sd8388607, 1, 1);
		// zero-length segment
		send_point(24'sd100, 24'sd100, 0, 0);
		send_point(24'sd100, 24'sd100, 1, 0);
		send_point(24'sd300, 24'sd50, 0, 1);
		// right angles
		send_point(0, 0, 0, 0);
		send_point(24'sd1000, 0, 1, 0);
		send_point(24'sd1000, -24'sd1000, 0, 0);
		send_point(0, -24'sd1000, 0, 1);
		wait_idle();
	endtask

	task automatic curve_path();
		send_point(0, 0, 1, 0);
		send_point(24'sd3000, 24'sd700, 1, 0);
		send_point(24'sd1000, 24'sd5000, 1, 0);
		send_point(-24'sd4000, 24'sd100, 0, 1);
	endtask

	task automatic test_register_extremes();
		reg_write(REG_CURVE, 0);
		reg_write(REG_DIST, 32'hFFFF);
		reg_write(REG_ANGLE, 32'hFFFF);
		curve_path();
		wait_idle();
		reg_write(REG_CURVE, 15);
		reg_write(REG_DIST, 0);
		reg_write(REG_ANGLE, 0);
		curve_path();
		wait_idle();
		reg_write(REG_ANGLE, 32'hFFFF);
		curve_path();
		wait_idle();
		reg_write(REG_DIST, 32'(DIST_WEIGHT_RST));
		reg_write(REG_ANGLE, 32'(ANGLE_WEIGHT_RST));
		reg_write(REG_CURVE, 32'(CURVE_FACTOR_RST));
	endtask

	// random paths: mostly three points or more, some short ones
	task automatic test_random_paths(int n_items);
		int sent, len, mode;
		logic signed [CW-1:0] x, y, lx, ly, ox, oy;
		sent = 0;
		x = 0; y = 0;
		lx = 0; ly = 0;
		ox = 0; oy = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				wait_idle();
				reg_write(REG_DIST, $urandom_range(0, 65535));
				reg_write(REG_ANGLE, $urandom_range(0, 65535));
				reg_write(REG_CURVE, $urandom_range(0, 15));
			end
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
			for (int i = 0; i < len; i++) begin
				mode = $urandom_range(0, 9);
				if (mode < 2) begin
					x = CW'($urandom); y = CW'($urandom);
				end else if (mode == 2) begin
					x = lx; y = ly;
				end else if (mode == 3) begin
					// step back along the previous segment
					x = ox; y = oy;
				end else begin
					x = lx + $signed(24'($urandom_range(0, 4000)) - 24'sd2000);
					y = ly + $signed(24'($urandom_range(0, 4000)) - 24'sd2000);
				end
				send_point(x, y, 1'($urandom_range(0, 1)), i == len - 1);
				ox = lx; oy = ly;
				lx = x; ly = y;
				sent++;
			end
		end
		wait_idle();
	endtask

	// run limit
	initial begin
		#10ms;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n = 0;
		s_tvalid = 0; s_tdata = '0; s_tuser = 0; s_tlast = 0;
		m_tready = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		w_dist = DIST_WEIGHT_RST;
		w_angle = ANGLE_WEIGHT_RST;
		k_curve = CURVE_FACTOR_RST;
		clear_path();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		repeat (SETTLE) @(negedge clk);
		test_short_paths();
		test_register_extremes();
		test_random_paths(2000);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

[path_length_turning_cost_unit.f]
rtl/plt_pkg.sv
rtl/plt_front.sv
rtl/plt_queue.sv
rtl/plt_back.sv
rtl/path_length_turning_cost_unit.sv
rtl/plt_checker.sv
tb/tb_path_length_turning_cost_unit.sv
